>>> src/cnp_pkg.sv
// ----------------------------------------------------------------------------
// cnp_pkg
// Types, codes and constant tables shared by the cpio newc stream parser.
// ----------------------------------------------------------------------------
package cnp_pkg;

	// parser phase, one-hot
	typedef enum logic [6:0] {
		PH_HEADER  = 7'b0000001,
		PH_NAME    = 7'b0000010,
		PH_NAMEPAD = 7'b0000100,
		PH_DATA    = 7'b0001000,
		PH_DATAPAD = 7'b0010000,
		PH_DONE    = 7'b0100000,
		PH_ERROR   = 7'b1000000
	} cnp_phase_t;

	// result kinds
	localparam logic [1:0] K_NAME  = 2'd0;
	localparam logic [1:0] K_DATA  = 2'd1;
	localparam logic [1:0] K_DONE  = 2'd2;
	localparam logic [1:0] K_ERROR = 2'd3;

	// error codes
	localparam logic [2:0] E_MAGIC   = 3'd0;
	localparam logic [2:0] E_HEX     = 3'd1;
	localparam logic [2:0] E_EMPTY   = 3'd2;
	localparam logic [2:0] E_UNTERM  = 3'd3;
	localparam logic [2:0] E_TRUNC   = 3'd4;

	// header layout
	localparam logic [6:0] HDR_LAST  = 7'd109;
	localparam logic [6:0] MAGIC_LEN = 7'd6;
	localparam logic [6:0] FSIZE_AT  = 7'd54;
	localparam logic [6:0] NSIZE_AT  = 7'd94;
	localparam logic [6:0] HEX_LEN   = 7'd8;

	// trailer name incl. its NUL
	localparam logic [3:0] TRL_LEN   = 4'd11;

	typedef struct packed {
		logic        valid;
		logic [1:0]  kind;
		logic [7:0]  byte_value;
		logic [31:0] file_size;
		logic        name_nul;
		logic        data_last;
		logic [2:0]  error_code;
	} cnp_res_t;

	function automatic logic [7:0] magic_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd1, 3'd3: c = 8'h37;
			3'd5:       c = 8'h31;
			default:    c = 8'h30;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] trailer_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:             c = 8'h54; // T
			4'd1:             c = 8'h52; // R
			4'd2:             c = 8'h41; // A
			4'd3:             c = 8'h49; // I
			4'd4:             c = 8'h4C; // L
			4'd5:             c = 8'h45; // E
			4'd6:             c = 8'h52; // R
			4'd7, 4'd8, 4'd9: c = 8'h21; // !
			default:          c = 8'h00;
		endcase
		return c;
	endfunction

	// {bad, nibble}
	function automatic logic [4:0] hex_nibble(input logic [7:0] b);
		logic [4:0] r;
		if (b inside {[8'h30:8'h39]}) begin
			r = {1'b0, 4'(b - 8'h30)};
		end else if (b inside {[8'h41:8'h46]}) begin
			r = {1'b0, 4'(b - 8'h37)};
		end else if (b inside {[8'h61:8'h66]}) begin
			r = {1'b0, 4'(b - 8'h57)};
		end else begin
			r = 5'b10000;
		end
		return r;
	endfunction

endpackage

>>> src/cnp_core.sv
// ----------------------------------------------------------------------------
// cnp_core
// Parser state and per-byte decode; gives at most one result per word.
// ----------------------------------------------------------------------------
module cnp_core #(
	parameter int ALIGN_BYTES = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       archive_byte,
	input  logic             first_byte,
	input  logic             last_byte,
	output cnp_pkg::cnp_res_t res
);
	import cnp_pkg::*;

	localparam int OW = (ALIGN_BYTES > 2) ? $clog2(ALIGN_BYTES) : 1;
	localparam logic [OW-1:0] OFF_TOP = OW'(ALIGN_BYTES - 1);

	cnp_phase_t    phase_q, ph, phase_d;
	logic [6:0]    hidx_q, hidx, hidx_d;
	logic [31:0]   nlen_q, nlen, nlen_d;
	logic [31:0]   esize_q, esize, esize_d;
	logic [31:0]   rem_q, rem, rem_d;
	logic [OW-1:0] off_q, off, off_d;
	logic          hexerr_q, hexerr, hexerr_d;
	logic          trl_q, trl, trl_d;
	logic [3:0]    nidx_q, nidx, nidx_d;
	logic [4:0]    hx;
	logic          stop;
	logic          off_zero;

	assign hx = hex_nibble(archive_byte);

	always_comb begin
		// first_byte restarts before the word is handled
		ph     = first_byte ? PH_HEADER : phase_q;
		hidx   = first_byte ? '0 : hidx_q;
		nlen   = first_byte ? '0 : nlen_q;
		esize  = first_byte ? '0 : esize_q;
		rem    = first_byte ? '0 : rem_q;
		off    = first_byte ? '0 : off_q;
		hexerr = first_byte ? 1'b0 : hexerr_q;
		trl    = first_byte ? 1'b1 : trl_q;
		nidx   = first_byte ? '0 : nidx_q;

		phase_d  = ph;
		hidx_d   = hidx;
		nlen_d   = nlen;
		esize_d  = esize;
		rem_d    = rem;
		off_d    = off;
		hexerr_d = hexerr;
		trl_d    = trl;
		nidx_d   = nidx;
		stop     = 1'b0;
		off_zero = 1'b0;
		res      = '0;

		if (ph != PH_DONE && ph != PH_ERROR) begin
			off_d    = (off == OFF_TOP) ? '0 : off + OW'(1);
			off_zero = (off_d == '0);
			case (ph)
				PH_HEADER: begin
					if (hidx == '0) begin
						nlen_d   = '0;
						esize_d  = '0;
						hexerr_d = 1'b0;
					end
					if (hidx < MAGIC_LEN) begin
						if (archive_byte != magic_char(hidx[2:0])) begin
							stop = 1'b1;
						end
					end else if (hidx >= FSIZE_AT && hidx < FSIZE_AT + HEX_LEN) begin
						if (hx[4]) hexerr_d = 1'b1;
						else       esize_d  = {esize_d[27:0], hx[3:0]};
					end else if (hidx >= NSIZE_AT && hidx < NSIZE_AT + HEX_LEN) begin
						if (hx[4]) hexerr_d = 1'b1;
						else       nlen_d   = {nlen_d[27:0], hx[3:0]};
					end
					if (stop) begin
						phase_d        = PH_ERROR;
						res.valid      = 1'b1;
						res.kind       = K_ERROR;
						res.error_code = E_MAGIC;
					end else if (hidx == HDR_LAST) begin
						hidx_d = '0;
						if (hexerr_d || nlen_d == '0) begin
							stop           = 1'b1;
							phase_d        = PH_ERROR;
							res.valid      = 1'b1;
							res.kind       = K_ERROR;
							res.error_code = hexerr_d ? E_HEX : E_EMPTY;
						end else begin
							phase_d = PH_NAME;
							rem_d   = nlen_d;
							trl_d   = 1'b1;
							nidx_d  = '0;
						end
					end else begin
						hidx_d = hidx + 7'd1;
					end
				end
				PH_NAME: begin
					if (nidx < TRL_LEN && archive_byte != trailer_char(nidx)) trl_d = 1'b0;
					if (nidx < TRL_LEN) nidx_d = nidx + 4'd1;
					rem_d = rem - 32'd1;
					if (rem != 32'd1) begin
						res.valid      = 1'b1;
						res.kind       = K_NAME;
						res.byte_value = archive_byte;
						res.file_size  = esize;
					end else if (archive_byte != 8'h00) begin
						stop           = 1'b1;
						phase_d        = PH_ERROR;
						res.valid      = 1'b1;
						res.kind       = K_ERROR;
						res.error_code = E_UNTERM;
					end else begin
						// name shorter than the trailer text cannot match
						if (nidx < TRL_LEN - 4'd1) trl_d = 1'b0;
						if (off_zero && trl_d) begin
							stop      = 1'b1;
							phase_d   = PH_DONE;
							res.valid = 1'b1;
							res.kind  = K_DONE;
						end else begin
							res.valid     = 1'b1;
							res.kind      = K_NAME;
							res.file_size = esize;
							res.name_nul  = 1'b1;
							if (!off_zero) begin
								phase_d = PH_NAMEPAD;
							end else if (esize != '0) begin
								phase_d = PH_DATA;
								rem_d   = esize;
							end else begin
								phase_d = PH_HEADER;
							end
						end
					end
				end
				PH_NAMEPAD: begin
					if (off_zero) begin
						if (trl) begin
							stop      = 1'b1;
							phase_d   = PH_DONE;
							res.valid = 1'b1;
							res.kind  = K_DONE;
						end else if (esize != '0) begin
							phase_d = PH_DATA;
							rem_d   = esize;
						end else begin
							phase_d = PH_HEADER;
						end
					end
				end
				PH_DATA: begin
					rem_d          = rem - 32'd1;
					res.valid      = 1'b1;
					res.kind       = K_DATA;
					res.byte_value = archive_byte;
					res.file_size  = esize;
					if (rem == 32'd1) begin
						res.data_last = 1'b1;
						phase_d       = off_zero ? PH_HEADER : PH_DATAPAD;
					end
				end
				PH_DATAPAD: begin
					if (off_zero) phase_d = PH_HEADER;
				end
				default: begin
					phase_d = ph;
				end
			endcase
			// truncation overrides an ordinary result
			if (last_byte && !stop) begin
				phase_d        = PH_ERROR;
				res            = '0;
				res.valid      = 1'b1;
				res.kind       = K_ERROR;
				res.error_code = E_TRUNC;
			end
		end
		res.valid = res.valid & accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			hidx_q   <= '0;
			nlen_q   <= '0;
			esize_q  <= '0;
			rem_q    <= '0;
			off_q    <= '0;
			hexerr_q <= 1'b0;
			trl_q    <= 1'b1;
			nidx_q   <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			hidx_q   <= hidx_d;
			nlen_q   <= nlen_d;
			esize_q  <= esize_d;
			rem_q    <= rem_d;
			off_q    <= off_d;
			hexerr_q <= hexerr_d;
			trl_q    <= trl_d;
			nidx_q   <= nidx_d;
		end
	end

endmodule

>>> src/cpio_newc_stream_parser.sv
// Output: each result is held in the output register, which loads it as its byte is taken.
// Throughput: one archive byte per cycle while the output is not stalled; per-byte decode is a single pass of logic.
// The input stalls only while a held result is itself stalled.
// Reset: asynchronous, clears to the header phase with an empty output register.
// ----------------------------------------------------------------------------
// cpio_newc_stream_parser
// Byte-stream cpio newc parser: header check, name and data pass-through.
// ----------------------------------------------------------------------------
module cpio_newc_stream_parser #(
	parameter int ALIGN_BYTES = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       archive_valid,
	output logic       archive_stall,
	input  logic [7:0] archive_byte,
	input  logic       first_byte,
	input  logic       last_byte,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [1:0] kind,
	output logic [7:0] byte_value,
	output logic [31:0] file_size,
	output logic       name_nul,
	output logic       data_last,
	output logic [2:0] error_code
);
	import cnp_pkg::*;

	logic     accept;
	logic     load;
	cnp_res_t res;
	cnp_res_t out_q;

	assign load          = !out_q.valid || !result_stall;
	assign archive_stall = !load;
	assign accept        = archive_valid && load;

	cnp_core #(
		.ALIGN_BYTES(ALIGN_BYTES)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.archive_byte(archive_byte),
		.first_byte  (first_byte),
		.last_byte   (last_byte),
		.res         (res)
	);

	// payload is don't-care while valid is low
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (load) begin
			out_q <= res;
		end
	end

	assign result_valid = out_q.valid;
	assign kind         = out_q.kind;
	assign byte_value   = out_q.byte_value;
	assign file_size    = out_q.file_size;
	assign name_nul     = out_q.name_nul;
	assign data_last    = out_q.data_last;
	assign error_code   = out_q.error_code;

`ifndef NO_ASSERTIONS
	a_end_words_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (kind == K_DONE || kind == K_ERROR)
		|-> byte_value == 8'h00 && file_size == '0 && !name_nul && !data_last)
		else $error("complete/error word carries payload");

	a_name_end_nul: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && name_nul |-> kind == K_NAME && byte_value == 8'h00)
		else $error("name end not on a NUL name word");

	a_data_end_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && data_last |-> kind == K_DATA && !name_nul)
		else $error("data end on a non-data word");

	a_code_only_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind != K_ERROR |-> error_code == E_MAGIC)
		else $error("error code set outside an error word");
`endif

endmodule

>>> tb/tb_cpio_newc_stream_parser.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cpio_newc_stream_parser
// Streams cpio newc archives through the parser one word at a time, predicts
// every name, data, completion and error result, and checks each in order.
// ----------------------------------------------------------------------------
module tb_cpio_newc_stream_parser;
	import cnp_pkg::*;

	localparam int ALIGN = 4;
	localparam int RAND_BYTES = 1300;
	localparam logic [47:0] MAGIC_TXT = "070701";
	localparam logic [87:0] TRL_TXT = {"TRAILER!!!", 8'h00};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        archive_valid = 1'b0;
	logic        archive_stall;
	logic [7:0]  archive_byte = 8'h00;
	logic        first_byte = 1'b0;
	logic        last_byte = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  byte_value;
	logic [31:0] file_size;
	logic        name_nul;
	logic        data_last;
	logic [2:0]  error_code;

	bit gaps_on = 1'b1;
	int mismatches = 0;
	int bytes_sent = 0;

	cnp_res_t   expected_events[$];
	logic [7:0] arch[$];

	// parser prediction state
	cnp_phase_t  m_phase = PH_HEADER;
	logic [6:0]  m_hdr_pos = '0;
	logic [31:0] m_name_len = '0;
	logic [31:0] m_file_size = '0;
	logic [31:0] m_left = '0;
	int unsigned m_align = 0;
	bit          m_hex_bad = 1'b0;
	bit          m_trl_ok = 1'b1;

	cpio_newc_stream_parser #(.ALIGN_BYTES(ALIGN)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.archive_valid(archive_valid),
		.archive_stall(archive_stall),
		.archive_byte(archive_byte),
		.first_byte(first_byte),
		.last_byte(last_byte),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.kind(kind),
		.byte_value(byte_value),
		.file_size(file_size),
		.name_nul(name_nul),
		.data_last(data_last),
		.error_code(error_code)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL cpio_newc_stream_parser");
		$finish;
	end

	always @(posedge clk) begin
		result_stall <= gaps_on && ($urandom_range(99) < 37);
	end

	// ------------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------------
	task automatic model_restart();
		m_phase = PH_HEADER;
		m_hdr_pos = '0;
		m_name_len = '0;
		m_file_size = '0;
		m_left = '0;
		m_align = 0;
		m_hex_bad = 1'b0;
		m_trl_ok = 1'b1;
	endtask

	// sticky end of an archive: error or completion
	task automatic model_end(input cnp_phase_t p, input logic [1:0] k, input logic [2:0] code);
		cnp_res_t r;
		r = '0;
		r.valid = 1'b1;
		r.kind = k;
		r.error_code = code;
		m_phase = p;
		expected_events.push_back(r);
	endtask

	function automatic logic [31:0] shift_hex(input logic [31:0] acc, input logic [7:0] c);
		logic [3:0] d;
		if (c >= "0" && c <= "9") begin
			d = 4'(c - "0");
		end else if (c >= "A" && c <= "F") begin
			d = 4'(c - "A" + 8'd10);
		end else if (c >= "a" && c <= "f") begin
			d = 4'(c - "a" + 8'd10);
		end else begin
			m_hex_bad = 1'b1;
			return acc;
		end
		return {acc[27:0], d};
	endfunction

	task automatic enter_data();
		if (m_file_size != 0) begin
			m_phase = PH_DATA;
			m_left = m_file_size;
		end else if (m_align == 0) begin
			m_phase = PH_HEADER;
		end else begin
			m_phase = PH_DATAPAD;
		end
	endtask

	task automatic parse_byte(input logic [7:0] b, input bit first, input bit last);
		cnp_res_t    r;
		bit          have;
		logic [31:0] pos;
		r = '0;
		r.valid = 1'b1;
		have = 1'b0;
		if (first) model_restart();
		if (m_phase == PH_DONE || m_phase == PH_ERROR) return;
		m_align = (m_align + 1) % ALIGN;
		case (m_phase)
			PH_HEADER: begin
				if (m_hdr_pos == 0) begin
					m_name_len = '0;
					m_file_size = '0;
					m_hex_bad = 1'b0;
				end
				if (m_hdr_pos < MAGIC_LEN) begin
					if (b != MAGIC_TXT[8*(5 - m_hdr_pos) +: 8]) begin
						model_end(PH_ERROR, K_ERROR, E_MAGIC);
						return;
					end
				end else if (m_hdr_pos >= FSIZE_AT && m_hdr_pos < FSIZE_AT + HEX_LEN) begin
					m_file_size = shift_hex(m_file_size, b);
				end else if (m_hdr_pos >= NSIZE_AT && m_hdr_pos < NSIZE_AT + HEX_LEN) begin
					m_name_len = shift_hex(m_name_len, b);
				end
				if (m_hdr_pos == HDR_LAST) begin
					m_hdr_pos = '0;
					// bad hex outranks an empty name
					if (m_hex_bad) begin
						model_end(PH_ERROR, K_ERROR, E_HEX);
						return;
					end
					if (m_name_len == 0) begin
						model_end(PH_ERROR, K_ERROR, E_EMPTY);
						return;
					end
					m_phase = PH_NAME;
					m_left = m_name_len;
					m_trl_ok = 1'b1;
				end else begin
					m_hdr_pos = m_hdr_pos + 1'b1;
				end
			end
			PH_NAME: begin
				pos = m_name_len - m_left;
				if (pos < TRL_LEN) begin
					if (b != TRL_TXT[8*(10 - pos[3:0]) +: 8]) m_trl_ok = 1'b0;
				end
				m_left = m_left - 1;
				if (m_left != 0) begin
					r.kind = K_NAME;
					r.byte_value = b;
					r.file_size = m_file_size;
					have = 1'b1;
				end else begin
					if (b != 8'h00) begin
						model_end(PH_ERROR, K_ERROR, E_UNTERM);
						return;
					end
					if (m_name_len < TRL_LEN) m_trl_ok = 1'b0;
					// trailer NUL already aligned: complete at once
					if (m_align == 0 && m_trl_ok) begin
						model_end(PH_DONE, K_DONE, E_MAGIC);
						return;
					end
					r.kind = K_NAME;
					r.file_size = m_file_size;
					r.name_nul = 1'b1;
					have = 1'b1;
					if (m_align == 0) enter_data();
					else m_phase = PH_NAMEPAD;
				end
			end
			PH_NAMEPAD: begin
				if (m_align == 0) begin
					if (m_trl_ok) begin
						model_end(PH_DONE, K_DONE, E_MAGIC);
						return;
					end
					enter_data();
				end
			end
			PH_DATA: begin
				m_left = m_left - 1;
				r.kind = K_DATA;
				r.byte_value = b;
				r.file_size = m_file_size;
				have = 1'b1;
				if (m_left == 0) begin
					r.data_last = 1'b1;
					if (m_align == 0) m_phase = PH_HEADER;
					else m_phase = PH_DATAPAD;
				end
			end
			default: begin
				if (m_align == 0) m_phase = PH_HEADER;
			end
		endcase
		if (last) model_end(PH_ERROR, K_ERROR, E_TRUNC);
		else if (have) expected_events.push_back(r);
	endtask

	// ------------------------------------------------------------------------
	// result check
	// ------------------------------------------------------------------------
	task automatic report(input string why, input cnp_res_t want, input cnp_res_t got);
		mismatches++;
		if (mismatches <= 10)
			$display({"%0t %s: exp k%0d b%02h s%08h ne%0b de%0b e%0d,",
				" got k%0d b%02h s%08h ne%0b de%0b e%0d"},
				$time, why, want.kind, want.byte_value, want.file_size, want.name_nul,
				want.data_last, want.error_code, got.kind, got.byte_value, got.file_size,
				got.name_nul, got.data_last, got.error_code);
	endtask

	always @(posedge clk) begin : check_out
		cnp_res_t want;
		cnp_res_t got;
		if (arst_n && result_valid && !result_stall) begin
			got = '0;
			got.valid = 1'b1;
			got.kind = kind;
			got.byte_value = byte_value;
			got.file_size = file_size;
			got.name_nul = name_nul;
			got.data_last = data_last;
			got.error_code = error_code;
			if (expected_events.size() == 0) begin
				report("unexpected result", '0, got);
			end else begin
				want = expected_events.pop_front();
				if (got !== want) report("mismatch", want, got);
			end
		end
	end

	// ------------------------------------------------------------------------
	// archive building
	// ------------------------------------------------------------------------
	task automatic put_hex8(input logic [31:0] v);
		logic [3:0] d;
		for (int i = 7; i >= 0; i--) begin
			d = v[4*i +: 4];
			if (d < 10) arch.push_back(8'h30 + d);
			else if ($urandom_range(1)) arch.push_back("A" + d - 8'd10);
			else arch.push_back("a" + d - 8'd10);
		end
	endtask

	task automatic add_header(input logic [31:0] fsize, input logic [31:0] nsize);
		for (int i = 0; i < 6; i++) arch.push_back(MAGIC_TXT[8*(5 - i) +: 8]);
		for (int f = 0; f < 13; f++) begin
			if (f == 6) put_hex8(fsize);
			else if (f == 11) put_hex8(nsize);
			else if ($urandom_range(3) == 0) repeat (8) arch.push_back(8'($urandom));
			else put_hex8($urandom);
		end
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) arch.push_back(s[i]);
	endtask

	task automatic pad_to_align();
		while (arch.size() % ALIGN != 0) arch.push_back(8'($urandom));
	endtask

	task automatic add_data(input int n);
		repeat (n) arch.push_back(8'($urandom));
	endtask

	task automatic add_entry(input string s, input int dsize);
		add_header(dsize, s.len() + 1);
		add_text(s);
		arch.push_back(8'h00);
		pad_to_align();
		add_data(dsize);
		pad_to_align();
	endtask

	// on_boundary: a longer trailer name whose NUL lands on an aligned offset
	task automatic add_trailer(input bit on_boundary);
		add_header(0, on_boundary ? 14 : 11);
		add_text("TRAILER!!!");
		arch.push_back(8'h00);
		if (on_boundary) begin
			add_text("ab");
			arch.push_back(8'h00);
		end
		pad_to_align();
	endtask

	task automatic random_entry();
		int nlen;
		int dsize;
		nlen = $urandom_range(1, 12);
		dsize = ($urandom_range(7) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 16);
		add_header(dsize, nlen + 1);
		repeat (nlen) arch.push_back(8'($urandom));
		arch.push_back(8'h00);
		pad_to_align();
		add_data(dsize);
		pad_to_align();
	endtask

	// ------------------------------------------------------------------------
	// sending
	// ------------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input bit first, input bit last);
		while (gaps_on && $urandom_range(99) < 37) begin
			archive_valid <= 1'b0;
			@(posedge clk);
		end
		archive_valid <= 1'b1;
		archive_byte <= b;
		first_byte <= first;
		last_byte <= last;
		do @(posedge clk); while (archive_stall);
		if (first || (m_phase != PH_DONE && m_phase != PH_ERROR)) bytes_sent++;
		parse_byte(b, first, last);
	endtask

	// sends arch[0..stop_at]; a negative stop_at sends it all
	task automatic send_arch(input bit use_first, input int stop_at, input bit mark_last);
		int last_idx;
		int spare;
		last_idx = (stop_at < 0) ? arch.size() - 1 : stop_at;
		spare = 0;
		for (int i = 0; i <= last_idx; i++) begin
			send_byte(arch[i], use_first && i == 0, mark_last && i == last_idx);
			// a couple of ignored words after the sticky end, then give up
			if (m_phase == PH_DONE || m_phase == PH_ERROR) begin
				if (spare == 2) break;
				spare++;
			end
		end
	endtask

	task automatic wait_idle();
		archive_valid <= 1'b0;
		while (expected_events.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task automatic test_reset_alignment();
		arch.delete();
		add_entry("a.txt", 5);
		add_entry("x", 0);
		add_entry("q", 7);
		add_trailer(1'b0);
		send_arch(1'b0, -1, 1'b0);
		wait_idle();
	endtask

	task automatic test_header_errors();
		for (int i = 0; i < 6; i++) begin
			arch.delete();
			add_header(0, 2);
			arch[i] = arch[i] ^ 8'($urandom_range(1, 255));
			send_arch(1'b1, -1, 1'b0);
		end
		// magic error on the final word beats truncation
		arch.delete();
		add_header(0, 2);
		arch[3] = arch[3] ^ 8'h01;
		send_arch(1'b1, 3, 1'b1);
		arch.delete();
		add_header(16, 4);
		arch[FSIZE_AT + 2] = "g";
		send_arch(1'b1, HDR_LAST, 1'b1);
		// zero name size plus a bad digit reports bad hex
		arch.delete();
		add_header(5, 0);
		arch[NSIZE_AT + 7] = "Z";
		send_arch(1'b1, -1, 1'b0);
		arch.delete();
		add_header(3, 0);
		send_arch(1'b1, -1, 1'b0);
	endtask

	task automatic test_name_cases();
		arch.delete();
		add_header(0, 4);
		add_text("abcd");
		pad_to_align();
		add_trailer(1'b0);
		send_arch(1'b1, -1, 1'b0);
		send_arch(1'b1, 113, 1'b1);
		arch.delete();
		add_entry("TRAILER!!!X", 3);
		add_entry("TRAIL", 2);
		add_header(2, 4);
		arch.push_back(8'hFF);
		arch.push_back(8'h00);
		arch.push_back(8'h80);
		arch.push_back(8'h00);
		pad_to_align();
		add_data(2);
		pad_to_align();
		add_trailer(1'b1);
		send_arch(1'b1, -1, 1'b1);
		arch.delete();
		add_entry("b", 1);
		add_header(0, 15);
		add_text("TRAILER!!!");
		arch.push_back(8'h00);
		add_text("xyz");
		arch.push_back(8'h00);
		pad_to_align();
		send_arch(1'b1, -1, 1'b0);
	endtask

	task automatic test_truncation();
		int cut_at [7];
		cut_at = '{2, 50, 111, 112, 114, 117, 119};
		arch.delete();
		add_entry("xy", 3);
		add_trailer(1'b0);
		foreach (cut_at[k]) send_arch(1'b1, cut_at[k], 1'b1);
		// completion on the final word wins over truncation
		send_arch(1'b1, -1, 1'b1);
		arch.push_back(8'($urandom));
		send_arch(1'b1, -1, 1'b1);
	endtask

	task automatic test_wide_sizes();
		logic [31:0] sizes [3];
		sizes = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h5A5A_A5A5};
		foreach (sizes[k]) begin
			arch.delete();
			add_header(sizes[k], 4);
			add_text("big");
			arch.push_back(8'h00);
			pad_to_align();
			add_data(6);
			send_arch(1'b1, -1, 1'b1);
		end
		arch.delete();
		add_header(1, 32'h0001_0000);
		add_data(20);
		send_arch(1'b1, -1, 1'b1);
	endtask

	task automatic test_back_to_back();
		gaps_on = 1'b0;
		arch.delete();
		add_entry("one", 9);
		add_entry("two.bin", 0);
		add_entry("three", 13);
		add_trailer(1'b0);
		send_arch(1'b1, -1, 1'b0);
		gaps_on = 1'b1;
		wait_idle();
	endtask

	task automatic test_random_archives();
		int mode;
		int cut;
		int idx;
		bytes_sent = 0;
		while (bytes_sent < RAND_BYTES) begin
			gaps_on = ($urandom_range(4) != 0);
			arch.delete();
			repeat ($urandom_range(1, 3)) random_entry();
			mode = $urandom_range(9);
			if (mode != 9) add_trailer($urandom_range(3) == 0);
			repeat ($urandom_range(2)) arch.push_back(8'($urandom));
			if (mode == 7) begin
				idx = $urandom_range(arch.size() - 1);
				arch[idx] = arch[idx] ^ 8'($urandom_range(1, 255));
			end
			cut = (mode == 8) ? $urandom_range(arch.size() - 1) : arch.size() - 1;
			send_arch(1'b1, cut, mode == 8 || $urandom_range(3) == 0);
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_alignment();
		test_header_errors();
		test_name_cases();
		test_truncation();
		test_wide_sizes();
		test_back_to_back();
		test_random_archives();
		archive_valid <= 1'b0;
		while (expected_events.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS cpio_newc_stream_parser");
		end else begin
			$display("FAIL cpio_newc_stream_parser");
		end
		$finish;
	end

endmodule
